// ----- rtl/mrrf_pkg.sv -----
// Package of the Modbus read request framer: request entry type, frame slot codes,
// protocol constants and the CRC-16/Modbus byte update function.
// No dependencies.
package mrrf_pkg;

	localparam logic [7:0]  FUNC_CODE_RESET = 8'h03;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  COUNT_HIGH_BYTE = 8'h00;

	// One queued read request, already paired with its function code
	typedef struct packed {
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [15:0] start_register;
		logic [7:0]  register_count;
	} req_entry_t;

	// Position of a byte within the eight-byte frame, in send order
	typedef enum logic [2:0] {
		SLOT_ADDR     = 3'd0,
		SLOT_FUNC     = 3'd1,
		SLOT_START_HI = 3'd2,
		SLOT_START_LO = 3'd3,
		SLOT_COUNT_HI = 3'd4,
		SLOT_COUNT_LO = 3'd5,
		SLOT_CRC_LO   = 3'd6,
		SLOT_CRC_HI   = 3'd7
	} frame_slot_t;

	// Fold one byte into a reflected CRC-16/Modbus value
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

// ----- rtl/mrrf_if.sv -----
// Channel interfaces of the Modbus read request framer: request input, frame byte
// output and the function code write channel. Depends on nothing.
interface mrrf_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  slave_address;
	logic [15:0] start_register;
	logic [7:0]  register_count;

	modport source (output valid, slave_address, start_register, register_count, input ready);
	modport sink   (input valid, slave_address, start_register, register_count, output ready);
endinterface

interface mrrf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface mrrf_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] function_code;

	modport source (output valid, function_code, input ready);
	modport sink   (input valid, function_code, output ready);
endinterface

// ----- rtl/mrrf_front.sv -----
// Front end of the framer: holds the function code register, accepts read requests
// and packs them into queue entries. Depends on mrrf_pkg and mrrf_if.
module mrrf_front (
	input  logic                clk,
	input  logic                arst_n,
	mrrf_req_if.sink            req,
	mrrf_cfg_if.sink            cfg,
	input  logic                q_full,
	output logic                push,
	output mrrf_pkg::req_entry_t push_entry
);
	import mrrf_pkg::*;

	logic [7:0] function_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_code_q <= FUNC_CODE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			function_code_q <= cfg.function_code;
		end
	end

	assign cfg.ready = 1'b1;
	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		push_entry.slave_address  = req.slave_address;
		push_entry.function_code  = function_code_q;
		push_entry.start_register = req.start_register;
		push_entry.register_count = req.register_count;
	end

endmodule

// ----- rtl/mrrf_queue.sv -----
// Short request queue between front and back end of the framer.
// Depends on mrrf_pkg.
module mrrf_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mrrf_pkg::req_entry_t push_entry,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output mrrf_pkg::req_entry_t head
);
	import mrrf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	req_entry_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("request queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !not_empty))
		else $error("request queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_CNT)
		else $error("request queue count beyond depth");

endmodule

// ----- rtl/mrrf_back.sv -----
// Back end of the framer: walks each queued request through the eight frame slots, folds the CRC
// one byte per cycle unless stalled, drives the output register. Depends on mrrf_pkg, mrrf_if.
module mrrf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  mrrf_pkg::req_entry_t q_head,
	output logic                 pop,
	mrrf_byte_if.source          frm
);
	import mrrf_pkg::*;

	logic        busy_q;
	frame_slot_t slot_q;
	req_entry_t  entry_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        advance;
	logic        active;
	frame_slot_t cur_slot;
	req_entry_t  cur_entry;
	logic [15:0] cur_crc;
	logic [7:0]  cur_byte;

	assign advance   = !out_valid_q || frm.ready;
	assign active    = busy_q || q_not_empty;
	assign cur_slot  = busy_q ? slot_q : SLOT_ADDR;
	assign cur_entry = busy_q ? entry_q : q_head;
	assign cur_crc   = busy_q ? crc_q : CRC_INIT;
	assign pop       = advance && !busy_q && q_not_empty;

	always_comb begin
		unique case (cur_slot)
			SLOT_ADDR:     cur_byte = cur_entry.slave_address;
			SLOT_FUNC:     cur_byte = cur_entry.function_code;
			SLOT_START_HI: cur_byte = cur_entry.start_register[15:8];
			SLOT_START_LO: cur_byte = cur_entry.start_register[7:0];
			SLOT_COUNT_HI: cur_byte = COUNT_HIGH_BYTE;
			SLOT_COUNT_LO: cur_byte = cur_entry.register_count;
			SLOT_CRC_LO:   cur_byte = cur_crc[7:0];
			SLOT_CRC_HI:   cur_byte = cur_crc[15:8];
			default:       cur_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= SLOT_ADDR;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= active;
			if (pop) begin
				busy_q <= 1'b1;
				slot_q <= SLOT_FUNC;
			end else if (busy_q) begin
				busy_q <= (slot_q != SLOT_CRC_HI);
				slot_q <= frame_slot_t'(slot_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && active) begin
			out_byte_q <= cur_byte;
			out_last_q <= (cur_slot == SLOT_CRC_HI);
			if (pop) begin
				entry_q <= q_head;
			end
			if (cur_slot != SLOT_CRC_LO && cur_slot != SLOT_CRC_HI) begin
				crc_q <= crc_byte(cur_crc, cur_byte);
			end
		end
	end

	assign frm.valid      = out_valid_q;
	assign frm.frame_byte = out_byte_q;
	assign frm.last_byte  = out_last_q;

	a_end_of_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && busy_q && slot_q == SLOT_CRC_HI) |=> !busy_q)
		else $error("sequencer did not release after the CRC high byte");
	a_busy_past_addr: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> slot_q != SLOT_ADDR)
		else $error("sequencer busy on the address slot");

endmodule

// ----- rtl/modbus_read_request_framer_unit.sv -----
// Top level of the Modbus RTU read request framer.
// Depends on mrrf_pkg, mrrf_if, mrrf_front, mrrf_queue and mrrf_back.
//
// Usage:
//   req  - read request transactions: slave address, start register, register count.
//   cfg  - write transactions to the function code register (reset value 3); always
//          ready. Write only while no frame is pending.
//   frm  - frame byte transactions, eight per request in send order: address,
//          function code, start high, start low, zero, count, CRC low, CRC high
//          (last_byte set on CRC high). CRC is CRC-16/Modbus over the first six bytes.
// Flow: an accepted request is stored in the queue; when the back end is free it takes
//   the request, registers its first byte in the output register, then each further byte.
// Throughput: one byte per cycle while frm.ready does not stall it, set by the single
//   byte sequencer in the back end. Requests queue (QUEUE_DEPTH deep) while it works,
//   and consecutive frames leave back to back.
// Stall: when frm.ready is low the output register holds its byte and the sequencer
//   waits; req.ready drops only once the queue is full.
// Reset: arst_n clears the queue, the sequencer and the output valid, and sets the
//   function code back to 3.
module modbus_read_request_framer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	mrrf_req_if.sink    req,
	mrrf_cfg_if.sink    cfg,
	mrrf_byte_if.source frm
);
	import mrrf_pkg::*;

	// Front to queue
	logic       push;
	req_entry_t push_entry;
	logic       q_full;

	// Queue to back
	logic       pop;
	logic       q_not_empty;
	req_entry_t q_head;

	// Accept requests, attach the current function code
	mrrf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple acceptance from frame emission
	mrrf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// Serialize frame bytes and fold the CRC
	mrrf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.frm         (frm)
	);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the Modbus RTU read request framer: drives requests and
// function code writes, predicts each eight-byte frame with its CRC and checks every byte.
// Depends on mrrf_pkg, the mrrf channel interfaces and modbus_read_request_framer_unit.
module tb;
	import mrrf_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned SETTLE       = 8;

	// One read request as offered on the request channel
	typedef struct {
		logic [7:0]  slave_address;
		logic [15:0] start_register;
		logic [7:0]  register_count;
	} read_req_t;

	// One frame byte as it should leave the block
	typedef struct {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	mrrf_req_if  req_ch ();
	mrrf_cfg_if  cfg_ch ();
	mrrf_byte_if frm_ch ();

	modbus_read_request_framer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.frm    (frm_ch)
	);

	// Requests waiting to be offered, function code writes waiting to go out,
	// and frame bytes predicted but not yet seen
	read_req_t   pending_requests [$];
	logic [7:0]  pending_fc_writes [$];
	frame_byte_t frame_bytes_due [$];

	// Function code as the block should hold it; updated on each write transaction
	logic [7:0] func_code_shadow;

	int unsigned sender_idle_pct   = 0;
	int unsigned receiver_idle_pct = 0;
	int unsigned hold_requests     = 0;
	int unsigned holds_served      = 0;
	int unsigned hold_left         = 0;
	int unsigned error_count       = 0;
	int unsigned cycle_count       = 0;

	always #1 clk = ~clk;

	// Build the frame a request should produce and append its bytes to the expected list.
	// The CRC is CRC-16/Modbus, reflected, folded bit by bit over the first six bytes.
	function automatic void predict_request_frame(input read_req_t rq, input logic [7:0] fcode);
		logic [7:0]  bytes [8];
		logic [15:0] crc;
		frame_byte_t fb;
		bytes[SLOT_ADDR]     = rq.slave_address;
		bytes[SLOT_FUNC]     = fcode;
		bytes[SLOT_START_HI] = rq.start_register[15:8];
		bytes[SLOT_START_LO] = rq.start_register[7:0];
		bytes[SLOT_COUNT_HI] = COUNT_HIGH_BYTE;
		bytes[SLOT_COUNT_LO] = rq.register_count;
		crc = CRC_INIT;
		for (int k = 0; k < 6; k++) begin
			crc = crc ^ {8'h00, bytes[k]};
			for (int b = 0; b < 8; b++) begin
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
		end
		bytes[SLOT_CRC_LO] = crc[7:0];
		bytes[SLOT_CRC_HI] = crc[15:8];
		for (int k = 0; k < 8; k++) begin
			fb.value = bytes[k];
			fb.last  = (k == SLOT_CRC_HI);
			frame_bytes_due.push_back(fb);
		end
	endfunction

	// Favor the extremes: all zeros and all ones each come up about one time in eight
	function automatic logic [15:0] pick_field(input int unsigned width);
		logic [15:0] mask;
		mask = 16'hFFFF >> (16 - width);
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return mask;
			default: return 16'($urandom()) & mask;
		endcase
	endfunction

	// Request driver: hand off the next pending request once the current one is taken,
	// and record the expected frame for each accepted transaction. The function code
	// channel is driven here as well; writes only happen while no frame is in flight.
	always @(posedge clk or negedge arst_n) begin
		read_req_t rq;
		if (!arst_n) begin
			req_ch.valid          <= 1'b0;
			req_ch.slave_address  <= 8'h00;
			req_ch.start_register <= 16'h0000;
			req_ch.register_count <= 8'h00;
			cfg_ch.valid          <= 1'b0;
			cfg_ch.function_code  <= 8'h00;
			func_code_shadow      = FUNC_CODE_RESET;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				func_code_shadow = cfg_ch.function_code;
			end
			if (!cfg_ch.valid || cfg_ch.ready) begin
				if (pending_fc_writes.size() > 0) begin
					cfg_ch.valid         <= 1'b1;
					cfg_ch.function_code <= pending_fc_writes.pop_front();
				end else begin
					cfg_ch.valid <= 1'b0;
				end
			end

			if (req_ch.valid && req_ch.ready) begin
				rq.slave_address  = req_ch.slave_address;
				rq.start_register = req_ch.start_register;
				rq.register_count = req_ch.register_count;
				predict_request_frame(rq, func_code_shadow);
			end
			// Advance only when the channel is empty or the current transaction just went
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					rq = pending_requests.pop_front();
					req_ch.valid          <= 1'b1;
					req_ch.slave_address  <= rq.slave_address;
					req_ch.start_register <= rq.start_register;
					req_ch.register_count <= rq.register_count;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Frame byte monitor: compare each accepted byte with the oldest prediction, then
	// pick the next ready level. A pending hold-off request drops ready until the
	// LONG_HOLD countdown ends, so the block's queue fills and the request side stalls.
	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		if (!arst_n) begin
			frm_ch.ready <= 1'b0;
		end else begin
			if (frm_ch.valid && frm_ch.ready) begin
				if (frame_bytes_due.size() == 0) begin
					$display("%0t tb: unexpected frame byte: expected none, got %02h last %0b",
						$time, frm_ch.frame_byte, frm_ch.last_byte);
					error_count++;
				end else begin
					want = frame_bytes_due.pop_front();
					if (frm_ch.frame_byte !== want.value || frm_ch.last_byte !== want.last) begin
						$display("%0t tb: frame byte mismatch: expected %02h last %0b, got %02h last %0b",
							$time, want.value, want.last, frm_ch.frame_byte, frm_ch.last_byte);
						error_count++;
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				frm_ch.ready <= 1'b0;
			end else begin
				frm_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Watchdog: drop out if the run stalls far beyond any correct completion
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic queue_request(input logic [7:0] addr, input logic [15:0] start,
		input logic [7:0] count);
		read_req_t rq;
		rq.slave_address  = addr;
		rq.start_register = start;
		rq.register_count = count;
		pending_requests.push_back(rq);
	endtask

	task automatic queue_random_requests(input int unsigned n);
		repeat (n) begin
			queue_request(8'(pick_field(8)), pick_field(16), 8'(pick_field(8)));
		end
	endtask

	// Hold the sender until every request is out and every predicted byte has arrived,
	// then let the back end settle
	task automatic wait_drained();
		while (pending_requests.size() > 0 || req_ch.valid || frame_bytes_due.size() > 0
			|| pending_fc_writes.size() > 0 || cfg_ch.valid) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_function_code(input logic [7:0] value);
		wait_drained();
		pending_fc_writes.push_back(value);
		wait_drained();
	endtask

	// Sequencing: control variables change on the falling edge only, so the clocked
	// processes above always see settled values
	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender mostly busy, receiver mostly stalled; function code at its reset value
		sender_idle_pct   = 10;
		receiver_idle_pct = 74;
		queue_request(8'h00, 16'h0000, 8'h00);
		queue_request(8'hFF, 16'hFFFF, 8'hFF);
		queue_request(8'h01, 16'h0000, 8'h0A);
		queue_request(8'h01, 16'h001E, 8'h08);
		queue_request(8'h11, 16'h006B, 8'h03);
		queue_request(8'h06, 16'h0006, 8'h1E);
		queue_request(8'h80, 16'h8000, 8'h80);
		queue_request(8'h7F, 16'h7FFF, 8'h7F);
		queue_request(8'hAA, 16'hAAAA, 8'h55);
		queue_request(8'h55, 16'h5555, 8'hAA);
		queue_request(8'h00, 16'h00FF, 8'h01);
		queue_request(8'hFF, 16'hFF00, 8'hFE);
		queue_request(8'h01, 16'h0001, 8'h00);
		queue_request(8'hF7, 16'h1234, 8'h00);
		queue_random_requests(60);

		// Function code zero
		write_function_code(8'h00);
		queue_request(8'h00, 16'h0000, 8'h00);
		queue_request(8'hFF, 16'hFFFF, 8'hFF);
		queue_random_requests(60);

		// Function code all ones; now the sender idles and the receiver rarely does
		write_function_code(8'hFF);
		sender_idle_pct   = 74;
		receiver_idle_pct = 10;
		queue_request(8'hFF, 16'hFFFF, 8'hFF);
		queue_random_requests(80);

		write_function_code(8'(pick_field(8)));
		queue_random_requests(60);

		// No idling at all; start with a long receiver hold-off while requests keep coming
		write_function_code(8'h03);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		hold_requests++;
		queue_random_requests(100);

		wait_drained();
		repeat (2 * SETTLE) @(negedge clk);
		if (error_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mrrf_pkg.sv
rtl/mrrf_if.sv
rtl/mrrf_front.sv
rtl/mrrf_queue.sv
rtl/mrrf_back.sv
rtl/modbus_read_request_framer_unit.sv
tb/sv/tb.sv
